[hw/rtl/afrl_pkg.sv]
// Package for the authentication failure rate limiter.
// Holds the codes, table entry layout and controller/datapath structs.
// No dependencies.
package afrl_pkg;

  // Field widths fixed by the item formats.
  localparam int unsigned UserW   = 32;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned CountW  = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 16;

  // Register values after reset.
  localparam logic [7:0]  MaxFailuresRst = 8'd5;
  localparam logic [15:0] WindowRst      = 16'd60;
  localparam logic [15:0] CooldownRst    = 16'd300;

  // Count value at which the failure counter saturates.
  localparam logic [CountW-1:0] CountMax = 8'hFF;

  typedef enum logic {
    OP_CHECK = 1'b0,
    OP_FAIL  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STATUS_ALLOWED  = 2'd0,
    STATUS_BLOCKED  = 2'd1,
    STATUS_RECORDED = 2'd2,
    STATUS_DROPPED  = 2'd3
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAX_FAILURES = 2'd0,
    CFG_WINDOW       = 2'd1,
    CFG_COOLDOWN     = 2'd2
  } cfg_reg_e;

  // One row of the lockout table.
  typedef struct packed {
    logic [UserW-1:0]  user;
    logic [CountW-1:0] failures;
    logic [TimeW-1:0]  window_start;
    logic [TimeW:0]    block_until;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan;
    logic update;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
  } stat_t;

endpackage

[hw/rtl/afrl_if.sv]
// Channel interfaces of the rate limiter: request items, result items and
// configuration writes. Depends on afrl_pkg.
interface afrl_item_if
  import afrl_pkg::*;
;
  logic             valid;
  logic             ready;
  logic             opcode;
  logic [UserW-1:0] user_id;
  logic [TimeW-1:0] now_seconds;

  modport source (output valid, opcode, user_id, now_seconds, input ready);
  modport sink   (input valid, opcode, user_id, now_seconds, output ready);
endinterface

interface afrl_result_if
  import afrl_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [CountW-1:0] failure_count;

  modport source (output valid, status, failure_count, input ready);
  modport sink   (input valid, status, failure_count, output ready);
endinterface

interface afrl_cfg_if
  import afrl_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CfgDatW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/auth_failure_rate_limiter_unit.sv]
// Top level of the authentication failure rate limiter.
// Depends on afrl_pkg, the channel interfaces, afrl_ctrl and afrl_dp.
//
//   channel    dir  interface       payload
//   item_in_i  in   afrl_item_if    opcode, user_id, now_seconds
//   result_o   out  afrl_result_if  status, failure_count
//   cfg_i      in   afrl_cfg_if     index, data (0 max_failures, 1 window, 2 cooldown)
//
// From acceptance to result an item is loaded, scanned against the table and
// updated; the scan reads one row per cycle and stops on a hit.
// Reset leaves the table empty and loads the register reset values.
// A result waits in its own register; the next item is accepted and scanned
// meanwhile and stalls before its update until that register is free.
// Configuration writes are taken in every cycle.
module auth_failure_rate_limiter_unit
  import afrl_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  afrl_item_if.sink     item_in_i,
  afrl_result_if.source result_o,
  afrl_cfg_if.sink      cfg_i
);

  cmd_t  cmd;
  stat_t stat;

  // Configuration writes complete at once.
  assign cfg_i.ready = 1'b1;

  afrl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_in_i.valid),
    .in_ready_o  (item_in_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  afrl_dp #(
    .TableEntries (TABLE_ENTRIES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .cfg_we_i        (cfg_i.valid),
    .cfg_index_i     (cfg_i.index),
    .cfg_data_i      (cfg_i.data),
    .opcode_i        (item_in_i.opcode),
    .user_id_i       (item_in_i.user_id),
    .now_seconds_i   (item_in_i.now_seconds),
    .status_o        (result_o.status),
    .failure_count_o (result_o.failure_count)
  );

endmodule

[hw/rtl/afrl_ctrl.sv]
// Controller of the rate limiter: sequences load, table scan and update,
// and owns the request and result handshakes. Depends on afrl_pkg.
module afrl_ctrl
  import afrl_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output cmd_t  cmd_o,
  input  stat_t stat_i
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_UPDATE = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_accept;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_accept   = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_done) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        // The result register must be free or emptying this cycle.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.update = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // The result stays valid until the sink takes it.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.update) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // An accepted item always goes to the scan.
  a_accept_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> state_q == ST_SCAN)
    else $error("accepted item did not start a scan");

  // An update never overwrites a result that is still waiting.
  a_update_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.update |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before it was taken");

  // An update always presents a result on the next cycle.
  a_update_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.update |=> out_valid_q)
    else $error("update did not present a result");

endmodule

[hw/rtl/afrl_dp.sv]
// Datapath of the rate limiter: configuration registers, the lockout table
// memory, the scan pipeline and the entry update logic. Depends on afrl_pkg.
module afrl_dp
  import afrl_pkg::*;
#(
  parameter int unsigned TableEntries = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output stat_t              stat_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgDatW-1:0] cfg_data_i,
  input  logic               opcode_i,
  input  logic [UserW-1:0]   user_id_i,
  input  logic [TimeW-1:0]   now_seconds_i,
  output logic [1:0]         status_o,
  output logic [CountW-1:0]  failure_count_o
);

  localparam int unsigned IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int unsigned CntW = $clog2(TableEntries + 1);
  localparam logic [CntW-1:0] Depth = CntW'(TableEntries);

  // Configuration registers.
  logic [7:0]  max_failures_q;
  logic [15:0] window_q;
  logic [15:0] cooldown_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_failures_q <= MaxFailuresRst;
      window_q       <= WindowRst;
      cooldown_q     <= CooldownRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MAX_FAILURES: max_failures_q <= cfg_data_i[7:0];
        CFG_WINDOW:       window_q       <= cfg_data_i;
        CFG_COOLDOWN:     cooldown_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Latched request item.
  op_e              op_q;
  logic [UserW-1:0] uid_q;
  logic [TimeW-1:0] now_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= op_e'(opcode_i);
      uid_q <= user_id_i;
      now_q <= now_seconds_i;
    end
  end

  // Table memory, one write and one registered read port.
  entry_t            mem_q [TableEntries];
  entry_t            rd_data_q;
  logic              rd_en;
  logic [IdxW-1:0]   rd_addr;
  logic              wr_en;
  logic [IdxW-1:0]   wr_addr;
  entry_t            wr_data;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // Scan: one read issued and one entry compared per cycle, until a match stops the reads.
  logic [CntW-1:0] used_q, used_d;
  logic [CntW-1:0] rd_ptr_q, rd_ptr_d;
  logic            pend_q, pend_d;
  logic [IdxW-1:0] pend_idx_q;
  logic            hit_q, hit_d;
  logic            match_now;

  assign match_now = pend_q && (rd_data_q.user == uid_q);
  assign rd_en     = cmd_i.scan && !hit_q && !match_now && (rd_ptr_q < used_q);
  assign rd_addr   = rd_ptr_q[IdxW-1:0];

  assign stat_o.scan_done = hit_q || (!pend_q && (rd_ptr_q >= used_q));

  always_comb begin
    rd_ptr_d = rd_ptr_q;
    pend_d   = pend_q;
    hit_d    = hit_q;
    if (cmd_i.load) begin
      rd_ptr_d = '0;
      pend_d   = 1'b0;
      hit_d    = 1'b0;
    end else if (cmd_i.scan) begin
      pend_d = rd_en;
      if (rd_en) begin
        rd_ptr_d = rd_ptr_q + CntW'(1);
      end
      if (match_now) begin
        hit_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      pend_q   <= 1'b0;
      hit_q    <= 1'b0;
      used_q   <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      pend_q   <= pend_d;
      hit_q    <= hit_d;
      used_q   <= used_d;
    end
  end

  // The index of the compared entry stays put once a match stops the reads.
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      pend_idx_q <= rd_addr;
    end
  end

  // Entry update and result.
  logic [TimeW:0]    cool_end;
  logic              blocked;
  logic [TimeW-1:0]  elapsed;
  logic              passed;
  logic [CountW-1:0] fail_cnt;
  logic              table_full;
  status_e           res_status;
  logic [CountW-1:0] res_count;
  logic              wr_any;
  logic              add_entry;

  always_comb begin
    cool_end   = {1'b0, now_q} + {{(TimeW + 1 - 16){1'b0}}, cooldown_q};
    blocked    = {1'b0, now_q} < rd_data_q.block_until;
    elapsed    = now_q - rd_data_q.window_start;
    passed     = (now_q > rd_data_q.window_start)
                 && (elapsed > {{(TimeW - 16){1'b0}}, window_q});
    fail_cnt   = (rd_data_q.failures == CountMax) ? CountMax
                 : rd_data_q.failures + CountW'(1);
    table_full = (used_q >= Depth);

    wr_any     = 1'b0;
    add_entry  = 1'b0;
    wr_addr    = pend_idx_q;
    wr_data    = rd_data_q;
    res_status = STATUS_ALLOWED;
    res_count  = '0;

    if (hit_q) begin
      if (op_q == OP_CHECK) begin
        if (blocked) begin
          res_status = STATUS_BLOCKED;
          res_count  = rd_data_q.failures;
        end else if (passed) begin
          // The window has run out: forget failures and cooldown.
          wr_any              = 1'b1;
          wr_data.failures    = '0;
          wr_data.block_until = '0;
        end else begin
          res_count = rd_data_q.failures;
        end
      end else begin
        wr_any           = 1'b1;
        wr_data.failures = fail_cnt;
        if (rd_data_q.failures == '0) begin
          wr_data.window_start = now_q;
        end
        if (fail_cnt >= max_failures_q) begin
          wr_data.block_until = cool_end;
        end
        res_status = STATUS_RECORDED;
        res_count  = fail_cnt;
      end
    end else if (op_q == OP_FAIL) begin
      if (!table_full) begin
        // First failure of an unknown user takes the next free row.
        wr_any               = 1'b1;
        add_entry            = 1'b1;
        wr_addr              = used_q[IdxW-1:0];
        wr_data.user         = uid_q;
        wr_data.failures     = CountW'(1);
        wr_data.window_start = now_q;
        wr_data.block_until  = (CountW'(1) >= max_failures_q) ? cool_end : '0;
        res_status           = STATUS_RECORDED;
        res_count            = CountW'(1);
      end else begin
        res_status = STATUS_DROPPED;
      end
    end

    wr_en  = cmd_i.update && wr_any;
    used_d = (cmd_i.update && add_entry) ? used_q + CntW'(1) : used_q;
  end

  // Result register, held until the next update.
  logic [1:0]        res_status_q;
  logic [CountW-1:0] res_count_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      res_status_q <= res_status;
      res_count_q  <= res_count;
    end
  end

  assign status_o        = res_status_q;
  assign failure_count_o = res_count_q;

  // The table never holds more rows than it has.
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= Depth)
    else $error("table fill count beyond depth");

  // The fill count only grows, one row at a time.
  a_used_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_q != $past(used_q)) |-> (used_q == $past(used_q) + CntW'(1)))
    else $error("table fill count jumped");

  // A hit always refers to the row holding the requested user.
  a_hit_user: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_q |-> (rd_data_q.user == uid_q))
    else $error("hit on a row of another user");

endmodule
